// ===== src/nearest_color_classifier_macros.svh =====
// Assertion macros for the nearest color classifier.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef NEAREST_COLOR_CLASSIFIER_MACROS_SVH
`define NEAREST_COLOR_CLASSIFIER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold a fixed number of cycles after the antecedent.
`define NCC_ASSERT_DELAY(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

// ===== src/ncc_pkg.sv =====
// Shared types, constants and helpers for the nearest color classifier.
// No dependencies.
`timescale 1ns / 1ps

package ncc_pkg;

  localparam int NUM_ENTRIES_DEF = 8;
  localparam int DIST_LIMIT_DEF  = 60;

  localparam int RAW_W    = 16;
  localparam int CHAN_W   = 8;
  localparam int ENTRY_W  = 24;
  localparam int IDX_W    = 3;
  localparam int DIST_W   = 18;
  localparam int DIVD_W   = RAW_W + CHAN_W;
  localparam int NUM_CH   = 3;

  localparam logic [1:0] ST_MATCH    = 2'd0;
  localparam logic [1:0] ST_NO_MATCH = 2'd1;
  localparam logic [1:0] ST_CLEAR_0  = 2'd2;

  // One color channel inside the divider: partial remainder and quotient so far
  typedef struct packed {
    logic [DIVD_W-1:0] rem;
    logic [CHAN_W-1:0] quo;
  } ncc_div_t;

  typedef struct packed {
    logic                    zero;
    logic [RAW_W-1:0]        clear;
    ncc_div_t [NUM_CH-1:0]   ch;
  } ncc_dpipe_t;

  typedef struct packed {
    logic              zero;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [DIST_W-1:0] best;
    logic [IDX_W-1:0]  idx;
    logic              found;
  } ncc_cpipe_t;

  function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
    logic [CHAN_W-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return {{CHAN_W{1'b0}}, d} * {{CHAN_W{1'b0}}, d};
  endfunction

endpackage

// ===== src/nearest_color_classifier.sv =====
// Nearest color classifier, top level. Uses ncc_pkg, ncc_div_stage and ncc_match_cell.
// A reading is taken on any cycle with start high; busy never rises, so one reading
// per clock is sustained. The result appears on the out_ ports for one cycle, marked
// by out_strobe, after one input stage, eight divider steps (one quotient bit each),
// one cell per reference color and one output register. The receiver cannot stall,
// so every result must be taken in its strobe cycle. The user must write reference
// colors via the cfg_ port only while no reading is in flight; it is not enforced.
`timescale 1ns / 1ps
`include "nearest_color_classifier_macros.svh"

module nearest_color_classifier
  import ncc_pkg::*;
#(
  parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int DIST_LIMIT  = DIST_LIMIT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [RAW_W-1:0]   in_raw_red,
  input  logic [RAW_W-1:0]   in_raw_green,
  input  logic [RAW_W-1:0]   in_raw_blue,
  input  logic [RAW_W-1:0]   in_raw_clear,
  output logic               out_strobe,
  output logic [1:0]         out_status,
  output logic [IDX_W-1:0]   out_match_index,
  output logic [CHAN_W-1:0]  out_norm_red,
  output logic [CHAN_W-1:0]  out_norm_green,
  output logic [CHAN_W-1:0]  out_norm_blue,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [ENTRY_W-1:0] cfg_data
);

  localparam int                LAT      = NUM_ENTRIES + 10;
  localparam logic [DIST_W-1:0] LIMIT_SQ = DIST_W'(DIST_LIMIT * DIST_LIMIT);

  logic       accept;
  logic       cfg_we;
  ncc_dpipe_t pre_nxt;
  logic       dvalid [0:CHAN_W];
  ncc_dpipe_t dpipe  [0:CHAN_W];
  logic       cvalid [0:NUM_ENTRIES];
  ncc_cpipe_t cpipe  [0:NUM_ENTRIES];
  logic [RAW_W-1:0] raw [NUM_CH];

  logic              out_valid_r;
  logic [1:0]        status_r, status_nxt;
  logic [IDX_W-1:0]  index_r, index_nxt;
  logic [CHAN_W-1:0] red_r, green_r, blue_r;
  logic [CHAN_W-1:0] red_nxt, green_nxt, blue_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign cfg_we    = cfg_valid && cfg_ready;

  assign raw[2] = in_raw_red;
  assign raw[1] = in_raw_green;
  assign raw[0] = in_raw_blue;

  // Scale by 255 and catch quotients past 255 before the divider
  always_comb begin
    logic [DIVD_W-1:0] prod;
    pre_nxt.zero  = (in_raw_clear == '0);
    pre_nxt.clear = in_raw_clear;
    for (int c = 0; c < NUM_CH; c++) begin
      prod = {raw[c], {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, raw[c]};
      if (prod >= {in_raw_clear, {CHAN_W{1'b0}}}) begin
        pre_nxt.ch[c].rem = '0;
        pre_nxt.ch[c].quo = '1;
      end else begin
        pre_nxt.ch[c].rem = prod;
        pre_nxt.ch[c].quo = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvalid[0] <= 1'b0;
    end else begin
      dvalid[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    dpipe[0] <= pre_nxt;
  end

  for (genvar s = 0; s < CHAN_W; s++) begin : g_div
    ncc_div_stage #(
      .BIT (CHAN_W - 1 - s)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .valid_in  (dvalid[s]),
      .data_in   (dpipe[s]),
      .valid_out (dvalid[s+1]),
      .data_out  (dpipe[s+1])
    );
  end

  assign cvalid[0]      = dvalid[CHAN_W];
  assign cpipe[0].zero  = dpipe[CHAN_W].zero;
  assign cpipe[0].red   = dpipe[CHAN_W].ch[2].quo;
  assign cpipe[0].green = dpipe[CHAN_W].ch[1].quo;
  assign cpipe[0].blue  = dpipe[CHAN_W].ch[0].quo;
  assign cpipe[0].best  = LIMIT_SQ;
  assign cpipe[0].idx   = '0;
  assign cpipe[0].found = 1'b0;

  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_cell
    ncc_match_cell #(
      .IDX (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cfg_we    (cfg_we),
      .cfg_index (cfg_index),
      .cfg_data  (cfg_data),
      .valid_in  (cvalid[k]),
      .data_in   (cpipe[k]),
      .valid_out (cvalid[k+1]),
      .data_out  (cpipe[k+1])
    );
  end

  always_comb begin
    red_nxt   = cpipe[NUM_ENTRIES].red;
    green_nxt = cpipe[NUM_ENTRIES].green;
    blue_nxt  = cpipe[NUM_ENTRIES].blue;
    index_nxt = '0;
    if (cpipe[NUM_ENTRIES].zero) begin
      status_nxt = ST_CLEAR_0;
      red_nxt    = '0;
      green_nxt  = '0;
      blue_nxt   = '0;
    end else if (cpipe[NUM_ENTRIES].found) begin
      status_nxt = ST_MATCH;
      index_nxt  = cpipe[NUM_ENTRIES].idx;
    end else begin
      status_nxt = ST_NO_MATCH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cvalid[NUM_ENTRIES];
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    index_r  <= index_nxt;
    red_r    <= red_nxt;
    green_r  <= green_nxt;
    blue_r   <= blue_nxt;
  end

  assign out_strobe      = out_valid_r;
  assign out_status      = status_r;
  assign out_match_index = index_r;
  assign out_norm_red    = red_r;
  assign out_norm_green  = green_r;
  assign out_norm_blue   = blue_r;

  `NCC_ASSERT_DELAY(a_fixed_latency, accept, LAT, out_strobe, "result beat missing at fixed latency")
  `NCC_ASSERT_SAME(a_nomatch_index, out_strobe && out_status != ST_MATCH, out_match_index == '0, "index set without a match")
  `NCC_ASSERT_SAME(a_zero_color, out_strobe && out_status == ST_CLEAR_0, out_norm_red == '0 && out_norm_green == '0 && out_norm_blue == '0, "color not cleared on zero clear")
  `NCC_ASSERT_SAME(a_index_range, out_strobe && out_status == ST_MATCH, int'(out_match_index) < NUM_ENTRIES, "match index beyond populated entries")

endmodule

// ===== src/ncc_div_stage.sv =====
// One restoring step of the normalizing divider, all three channels at once.
// Depends on ncc_pkg.
`timescale 1ns / 1ps

module ncc_div_stage
  import ncc_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       valid_in,
  input  ncc_dpipe_t data_in,
  output logic       valid_out,
  output ncc_dpipe_t data_out
);

  logic       valid_r;
  ncc_dpipe_t data_r, data_nxt;
  logic [DIVD_W-1:0] shifted;

  assign shifted = {{CHAN_W{1'b0}}, data_in.clear} << BIT;

  always_comb begin
    data_nxt = data_in;
    for (int c = 0; c < NUM_CH; c++) begin
      if (data_in.ch[c].rem >= shifted) begin
        data_nxt.ch[c].rem      = data_in.ch[c].rem - shifted;
        data_nxt.ch[c].quo[BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

// ===== src/ncc_match_cell.sv =====
// One reference color cell: holds its entry and updates the running best match.
// Depends on ncc_pkg.
`timescale 1ns / 1ps

module ncc_match_cell
  import ncc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [ENTRY_W-1:0] cfg_data,
  input  logic               valid_in,
  input  ncc_cpipe_t         data_in,
  output logic               valid_out,
  output ncc_cpipe_t         data_out
);

  logic [ENTRY_W-1:0] entry_r;
  logic               valid_r;
  ncc_cpipe_t         data_r, data_nxt;
  logic [DIST_W-1:0]  sq_dist;

  always_comb begin
    sq_dist = DIST_W'(sq_diff(data_in.red,   entry_r[23:16]))
            + DIST_W'(sq_diff(data_in.green, entry_r[15:8]))
            + DIST_W'(sq_diff(data_in.blue,  entry_r[7:0]));
    data_nxt = data_in;
    // strict compare: an earlier entry keeps a tie
    if (sq_dist < data_in.best) begin
      data_nxt.best  = sq_dist;
      data_nxt.idx   = IDX_W'(IDX);
      data_nxt.found = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
      valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == IDX_W'(IDX)) begin
        entry_r <= cfg_data;
      end
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_out = valid_r;
  assign data_out  = data_r;

endmodule

// ===== tb/tb_nearest_color_classifier.sv =====
// Self-checking testbench for nearest_color_classifier: directed readings, then
// random bursts over several reference palettes. Depends on ncc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_nearest_color_classifier;
  import ncc_pkg::*;

  localparam int LATENCY = NUM_ENTRIES_DEF + 12;

  typedef struct packed {
    logic [1:0]        status;
    logic [IDX_W-1:0]  index;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } color_verdict_t;

  typedef enum int {PAL_RANDOM, PAL_BLACK, PAL_WHITE, PAL_DUPLICATES, PAL_CLUSTER} palette_kind_t;

  class color_scoreboard;
    logic [ENTRY_W-1:0] palette [NUM_ENTRIES_DEF];
    color_verdict_t verdicts_due [$];
    int errors, readings, matched, missed, dark;

    function new();
      foreach (palette[k]) palette[k] = '0;
      errors = 0;
      readings = 0;
      matched = 0;
      missed = 0;
      dark = 0;
    endfunction

    function void load_entry(int k, logic [ENTRY_W-1:0] rgb);
      palette[k] = rgb;
    endfunction

    function logic [CHAN_W-1:0] scale_channel(logic [RAW_W-1:0] raw, logic [RAW_W-1:0] clear);
      int unsigned q;
      q = (int'(raw) * 255) / int'(clear);
      return (q > 255) ? 8'hFF : q[CHAN_W-1:0];
    endfunction

    function color_verdict_t classify_reading(logic [RAW_W-1:0] r, logic [RAW_W-1:0] g,
                                              logic [RAW_W-1:0] b, logic [RAW_W-1:0] c);
      color_verdict_t v;
      int unsigned best, sq_dist;
      int dr, dg, db;
      v = '0;
      if (c == '0) begin
        v.status = ST_CLEAR_0;
        return v;
      end
      v.red    = scale_channel(r, c);
      v.green  = scale_channel(g, c);
      v.blue   = scale_channel(b, c);
      v.status = ST_NO_MATCH;
      best = DIST_LIMIT_DEF * DIST_LIMIT_DEF;
      // strict compare: on a tie the earlier entry keeps the match
      for (int k = 0; k < NUM_ENTRIES_DEF; k++) begin
        dr = int'(v.red)   - int'(palette[k][23:16]);
        dg = int'(v.green) - int'(palette[k][15:8]);
        db = int'(v.blue)  - int'(palette[k][7:0]);
        sq_dist = dr * dr + dg * dg + db * db;
        if (sq_dist < best) begin
          best = sq_dist;
          v.index = IDX_W'(k);
          v.status = ST_MATCH;
        end
      end
      return v;
    endfunction

    function void note_reading(logic [RAW_W-1:0] r, logic [RAW_W-1:0] g,
                               logic [RAW_W-1:0] b, logic [RAW_W-1:0] c);
      verdicts_due.push_back(classify_reading(r, g, b, c));
      readings++;
    endfunction

    task flag_mismatch(string what);
      errors++;
      $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    task check_result(color_verdict_t got);
      color_verdict_t want;
      if (verdicts_due.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing due: %p", got));
        return;
      end
      want = verdicts_due.pop_front();
      if (got.status != want.status)
        flag_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.index != want.index)
        flag_mismatch($sformatf("match_index %0d, want %0d", got.index, want.index));
      if (got.red != want.red)
        flag_mismatch($sformatf("norm_red %0d, want %0d", got.red, want.red));
      if (got.green != want.green)
        flag_mismatch($sformatf("norm_green %0d, want %0d", got.green, want.green));
      if (got.blue != want.blue)
        flag_mismatch($sformatf("norm_blue %0d, want %0d", got.blue, want.blue));
      case (want.status)
        ST_MATCH:    matched++;
        ST_NO_MATCH: missed++;
        default:     dark++;
      endcase
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [RAW_W-1:0] in_raw_red = '0;
  logic [RAW_W-1:0] in_raw_green = '0;
  logic [RAW_W-1:0] in_raw_blue = '0;
  logic [RAW_W-1:0] in_raw_clear = '0;
  logic out_strobe;
  logic [1:0] out_status;
  logic [IDX_W-1:0] out_match_index;
  logic [CHAN_W-1:0] out_norm_red, out_norm_green, out_norm_blue;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [ENTRY_W-1:0] cfg_data = '0;

  color_scoreboard sb = new();
  logic [ENTRY_W-1:0] staged_palette [NUM_ENTRIES_DEF];
  int palettes_loaded = 0;

  nearest_color_classifier u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_raw_red      (in_raw_red),
    .in_raw_green    (in_raw_green),
    .in_raw_blue     (in_raw_blue),
    .in_raw_clear    (in_raw_clear),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_match_index (out_match_index),
    .out_norm_red    (out_norm_red),
    .out_norm_green  (out_norm_green),
    .out_norm_blue   (out_norm_blue),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample pre-edge values: result beats first, then the input beat taken at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe)
        sb.check_result({out_status, out_match_index, out_norm_red, out_norm_green,
                         out_norm_blue});
      if (start && !busy)
        sb.note_reading(in_raw_red, in_raw_green, in_raw_blue, in_raw_clear);
    end
  end

  task automatic send_reading(input logic [RAW_W-1:0] r, input logic [RAW_W-1:0] g,
                              input logic [RAW_W-1:0] b, input logic [RAW_W-1:0] c);
    in_raw_red   <= r;
    in_raw_green <= g;
    in_raw_blue  <= b;
    in_raw_clear <= c;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold off until every due result has come, then let the pipe empty.
  task automatic wait_quiet();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (sb.verdicts_due.size() != 0 && guard < 20 * LATENCY) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic load_palette();
    for (int k = 0; k < NUM_ENTRIES_DEF; k++) begin
      cfg_index <= IDX_W'(k);
      cfg_data  <= staged_palette[k];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      sb.load_entry(k, staged_palette[k]);
    end
    cfg_valid <= 1'b0;
    palettes_loaded++;
  endtask

  function automatic int clamp_chan(input int v);
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  task automatic stage_palette(input palette_kind_t kind);
    logic [ENTRY_W-1:0] base;
    int src;
    base = ENTRY_W'($urandom);
    for (int k = 0; k < NUM_ENTRIES_DEF; k++) begin
      case (kind)
        PAL_BLACK: staged_palette[k] = '0;
        PAL_WHITE: staged_palette[k] = '1;
        PAL_CLUSTER: begin
          staged_palette[k][23:16] = 8'(clamp_chan(int'(base[23:16]) + $urandom_range(0, 60) - 30));
          staged_palette[k][15:8]  = 8'(clamp_chan(int'(base[15:8])  + $urandom_range(0, 60) - 30));
          staged_palette[k][7:0]   = 8'(clamp_chan(int'(base[7:0])   + $urandom_range(0, 60) - 30));
        end
        default: staged_palette[k] = ENTRY_W'($urandom);
      endcase
    end
    if (kind == PAL_DUPLICATES) begin
      // copy earlier entries forward so ties are common
      for (int k = 1; k < NUM_ENTRIES_DEF; k++) begin
        if ($urandom_range(0, 1) == 1) begin
          src = $urandom_range(0, k - 1);
          staged_palette[k] = staged_palette[src];
        end
      end
    end
  endtask

  task automatic random_reading(output logic [RAW_W-1:0] r, output logic [RAW_W-1:0] g,
                                output logic [RAW_W-1:0] b, output logic [RAW_W-1:0] c);
    int pick, k, target;
    int unsigned raw;
    logic [ENTRY_W-1:0] e;
    logic [RAW_W-1:0] chan [3];
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: c = RAW_W'($urandom);
      1: c = RAW_W'($urandom_range(1, 255));
      default: c = RAW_W'($urandom_range(256, 65535));
    endcase
    if (pick < 25) begin
      r = RAW_W'($urandom);
      g = RAW_W'($urandom);
      b = RAW_W'($urandom);
      if (pick < 8) c = '0;
    end else begin
      // aim the normalized color near one reference entry
      k = $urandom_range(0, NUM_ENTRIES_DEF - 1);
      e = sb.palette[k];
      for (int ch = 0; ch < 3; ch++) begin
        target = clamp_chan(int'(e[8*(2-ch) +: 8]) + $urandom_range(0, 80) - 40);
        raw = (target * int'(c)) / 255 + $urandom_range(0, int'(c) / 255);
        chan[ch] = (raw > 65535) ? 16'hFFFF : RAW_W'(raw);
      end
      r = chan[0];
      g = chan[1];
      b = chan[2];
    end
  endtask

  task automatic run_traffic(input int count);
    int sent, burst;
    logic [RAW_W-1:0] r, g, b, c;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int n = 0; n < burst && sent < count; n++) begin
        random_reading(r, g, b, c);
        send_reading(r, g, b, c);
        sent++;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3: ;
        4, 5, 6, 7: pause_sender($urandom_range(1, 5));
        8:          pause_sender($urandom_range(10, 25));
        default:    wait_quiet();
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset palette is all black
    send_reading(16'd0, 16'd0, 16'd0, 16'd255);
    send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_reading(16'h1234, 16'hABCD, 16'hFFFF, 16'd0);
    wait_quiet();

    staged_palette[0] = 24'hFF0000;
    staged_palette[1] = 24'h00FF00;
    staged_palette[2] = 24'h0000FF;
    staged_palette[3] = 24'h000000;
    staged_palette[4] = 24'hFFFFFF;
    staged_palette[5] = 24'h646464;
    staged_palette[6] = 24'h786464;
    staged_palette[7] = 24'h0000FF;
    load_palette();

    // clear of 255 passes each raw value through unchanged
    for (int k = 0; k < NUM_ENTRIES_DEF; k++)
      send_reading(16'(staged_palette[k][23:16]), 16'(staged_palette[k][15:8]),
                   16'(staged_palette[k][7:0]), 16'd255);
    send_reading(16'd110, 16'd100, 16'd100, 16'd255);  // tie between two entries
    send_reading(16'd60, 16'd0, 16'd0, 16'd255);       // exactly on the limit
    send_reading(16'd59, 16'd0, 16'd0, 16'd255);       // just inside the limit
    send_reading(16'hFFFF, 16'd0, 16'd0, 16'd1);       // saturation
    send_reading(16'd0, 16'd0, 16'd0, 16'd1);
    send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0); // clear zero
    send_reading(16'd200, 16'd50, 16'd150, 16'd255);   // far from every entry
    send_reading(16'h5555, 16'hAAAA, 16'h8001, 16'hFFFF);
    send_reading(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    wait_quiet();

    stage_palette(PAL_RANDOM);
    load_palette();
    run_traffic(400);
    wait_quiet();
    stage_palette(PAL_BLACK);
    load_palette();
    run_traffic(400);
    wait_quiet();
    stage_palette(PAL_DUPLICATES);
    load_palette();
    run_traffic(400);
    wait_quiet();
    stage_palette(PAL_WHITE);
    load_palette();
    run_traffic(400);
    wait_quiet();
    stage_palette(PAL_CLUSTER);
    load_palette();
    run_traffic(400);
    wait_quiet();

    if (sb.verdicts_due.size() != 0)
      sb.flag_mismatch($sformatf("%0d results never arrived", sb.verdicts_due.size()));
    $display("Classified %0d readings over %0d palettes.", sb.readings, palettes_loaded);
    $display("Matched %0d, no match %0d, clear zero %0d; %0d mismatches.",
             sb.matched, sb.missed, sb.dark, sb.errors);
    if (sb.errors == 0) begin
      $display("tb_nearest_color_classifier: clean");
    end else begin
      $display("tb_nearest_color_classifier: errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timed out waiting on the block.");
    $display("tb_nearest_color_classifier: errors");
    $finish;
  end

endmodule

// ===== nearest_color_classifier.f =====
+incdir+src
src/ncc_pkg.sv
src/ncc_div_stage.sv
src/ncc_match_cell.sv
src/nearest_color_classifier.sv
tb/tb_nearest_color_classifier.sv
